FILE: rtl/yaz0_pkg.sv
`default_nettype none

package yaz0_pkg;

  // defaults for the top level parameters
  localparam int WINDOW_DEF = 4096;
  localparam int HEADER_DEF = 16;
  localparam int LANES_DEF  = 8;

  // field and register widths fixed by the stream format
  localparam int SIZE_W = 27;
  localparam int HDR_W  = 5;
  localparam int LANE_W = 4;
  localparam int OUT_W  = 64;
  localparam int LEN_W  = 9;
  localparam int DIST_W = 12;
  localparam int TDATA_OUT_W = 72;

  localparam logic [3:0]       CODE_BITS  = 4'd8;
  localparam logic [LEN_W-1:0] SHORT_BIAS = 9'd2;
  localparam logic [LEN_W-1:0] EXT_BIAS   = 9'h012;

  typedef enum logic [2:0] {
    PH_CODE,
    PH_LIT,
    PH_REF1,
    PH_REF2,
    PH_EXT
  } phase_t;

  typedef enum logic [1:0] {
    ST_ACCEPT,
    ST_COPY_RD,
    ST_COPY_WR
  } state_t;

  typedef struct packed {
    logic accept;
    logic rd;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic copy_start;
    logic copy_end;
    logic emit_ok;
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/yaz0_ram.sv
`default_nettype none

module yaz0_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/yaz0_ctrl.sv
`default_nettype none

module yaz0_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  input  wire yaz0_pkg::status_t status,
  output yaz0_pkg::cmd_t         cmd
);

  yaz0_pkg::state_t state;
  yaz0_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= yaz0_pkg::ST_ACCEPT;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      yaz0_pkg::ST_ACCEPT: begin
        if (s_tvalid && status.out_free && status.copy_start) begin
          state_next = yaz0_pkg::ST_COPY_RD;
        end
      end
      yaz0_pkg::ST_COPY_RD: begin
        state_next = yaz0_pkg::ST_COPY_WR;
      end
      yaz0_pkg::ST_COPY_WR: begin
        if (status.emit_ok) begin
          state_next = status.copy_end ? yaz0_pkg::ST_ACCEPT : yaz0_pkg::ST_COPY_RD;
        end
      end
      default: begin
        state_next = yaz0_pkg::ST_ACCEPT;
      end
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    case (state)
      yaz0_pkg::ST_ACCEPT:  cmd.accept = status.out_free;
      yaz0_pkg::ST_COPY_RD: cmd.rd = 1'b1;
      yaz0_pkg::ST_COPY_WR: cmd.emit = status.emit_ok;
      default:              cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/yaz0_dp.sv
`default_nettype none

module yaz0_dp #(
  parameter int WINDOW_BYTES = yaz0_pkg::WINDOW_DEF,
  parameter int HEADER_BYTES = yaz0_pkg::HEADER_DEF,
  parameter int LANES        = yaz0_pkg::LANES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire yaz0_pkg::cmd_t                cmd,
  output yaz0_pkg::status_t                  status,
  input  wire logic                          s_tvalid,
  input  wire logic [7:0]                    s_tdata,
  input  wire logic                          s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [yaz0_pkg::TDATA_OUT_W-1:0]   m_tdata,
  output logic                               m_tlast,
  output logic                               m_tuser,
  input  wire logic                          cfg_wr,
  input  wire logic [yaz0_pkg::SIZE_W-1:0]   cfg_data
);

  localparam int AW = $clog2(WINDOW_BYTES);
  localparam int SW = yaz0_pkg::SIZE_W;
  localparam int HW = yaz0_pkg::HDR_W;
  localparam int LW = yaz0_pkg::LANE_W;
  localparam int NW = yaz0_pkg::LEN_W;
  localparam logic [HW-1:0] HDR_RST = HW'(HEADER_BYTES);
  localparam logic [LW-1:0] LANE_MAX = LW'(LANES);

  // parser state
  logic [SW-1:0]    out_size;
  logic [HW-1:0]    header_left, header_left_next;
  logic [7:0]       code_bits, code_bits_next;
  logic [3:0]       bits_left, bits_left_next;
  yaz0_pkg::phase_t phase, phase_next;
  logic [7:0]       ref_first, ref_first_next;
  logic [7:0]       ref_second, ref_second_next;
  logic [SW-1:0]    out_count, out_count_next;

  // copy engine and packing
  logic [NW-1:0]    copy_len;
  logic [AW-1:0]    src_ptr;
  logic [63:0]      acc_bytes, acc_new;
  logic [LW-1:0]    acc_lanes, lanes_inc;

  // output register
  logic             out_valid;
  logic [63:0]      out_bytes;
  logic [LW-1:0]    out_lanes;
  logic             out_last;
  logic             out_done;

  logic             fire;
  logic [HW-1:0]    e_hl;
  logic [7:0]       e_code, e_rf, e_rs;
  logic [3:0]       e_bits;
  yaz0_pkg::phase_t e_phase;
  logic [SW-1:0]    e_oc, e_oc_inc, oc_inc;
  logic             in_hdr, active, lit, copy_start;
  logic [7:0]       ni_code;
  logic [3:0]       ni_bits;
  yaz0_pkg::phase_t ni_phase;
  logic [NW-1:0]    start_len;
  logic [yaz0_pkg::DIST_W-1:0] start_dist;
  logic [AW-1:0]    src_start;
  logic             copy_end, flush_need, out_free;
  logic             lit_load, copy_load, out_load;
  logic             ram_wr_en;
  logic [AW-1:0]    ram_wr_addr;
  logic [7:0]       ram_wr_data, ram_q;

  assign fire = s_tvalid && cmd.accept;

  // state as seen by this item: first_of_stream restarts the parser state
  always_comb begin
    if (s_tuser) begin
      e_hl    = HDR_RST;
      e_code  = '0;
      e_bits  = '0;
      e_phase = yaz0_pkg::PH_CODE;
      e_rf    = '0;
      e_rs    = '0;
      e_oc    = '0;
    end else begin
      e_hl    = header_left;
      e_code  = code_bits;
      e_bits  = bits_left;
      e_phase = phase;
      e_rf    = ref_first;
      e_rs    = ref_second;
      e_oc    = out_count;
    end
  end

  assign e_oc_inc = e_oc + SW'(1);
  assign in_hdr   = (e_hl != '0);
  assign active   = !in_hdr && (e_oc < out_size);
  assign lit      = active && (e_phase == yaz0_pkg::PH_LIT);
  assign copy_start = active && (((e_phase == yaz0_pkg::PH_REF2) && (e_rf[7:4] != 4'h0))
                                 || (e_phase == yaz0_pkg::PH_EXT));

  // advance to the next code bit
  assign ni_code  = {e_code[6:0], 1'b0};
  assign ni_bits  = (e_bits != 4'h0) ? e_bits - 4'd1 : 4'h0;
  assign ni_phase = (ni_bits == 4'h0) ? yaz0_pkg::PH_CODE
                  : (ni_code[7] ? yaz0_pkg::PH_LIT : yaz0_pkg::PH_REF1);

  always_comb begin
    if (e_phase == yaz0_pkg::PH_EXT) begin
      start_len  = NW'(s_tdata) + yaz0_pkg::EXT_BIAS;
      start_dist = {e_rf[3:0], e_rs};
    end else begin
      start_len  = NW'(e_rf[7:4]) + yaz0_pkg::SHORT_BIAS;
      start_dist = {e_rf[3:0], s_tdata};
    end
  end

  assign src_start = e_oc[AW-1:0] - AW'(start_dist) - AW'(1);

  always_comb begin
    header_left_next = header_left;
    code_bits_next   = code_bits;
    bits_left_next   = bits_left;
    phase_next       = phase;
    ref_first_next   = ref_first;
    ref_second_next  = ref_second;
    out_count_next   = out_count;
    if (fire) begin
      header_left_next = e_hl;
      code_bits_next   = e_code;
      bits_left_next   = e_bits;
      phase_next       = e_phase;
      ref_first_next   = e_rf;
      ref_second_next  = e_rs;
      out_count_next   = e_oc;
      if (in_hdr) begin
        header_left_next = e_hl - HW'(1);
      end else if (active) begin
        case (e_phase)
          yaz0_pkg::PH_CODE: begin
            code_bits_next = s_tdata;
            bits_left_next = yaz0_pkg::CODE_BITS;
            phase_next     = s_tdata[7] ? yaz0_pkg::PH_LIT : yaz0_pkg::PH_REF1;
          end
          yaz0_pkg::PH_LIT: begin
            out_count_next = e_oc_inc;
            code_bits_next = ni_code;
            bits_left_next = ni_bits;
            phase_next     = ni_phase;
          end
          yaz0_pkg::PH_REF1: begin
            ref_first_next = s_tdata;
            phase_next     = yaz0_pkg::PH_REF2;
          end
          yaz0_pkg::PH_REF2: begin
            ref_second_next = s_tdata;
            if (e_rf[7:4] == 4'h0) begin
              phase_next = yaz0_pkg::PH_EXT;
            end else begin
              code_bits_next = ni_code;
              bits_left_next = ni_bits;
              phase_next     = ni_phase;
            end
          end
          yaz0_pkg::PH_EXT: begin
            code_bits_next = ni_code;
            bits_left_next = ni_bits;
            phase_next     = ni_phase;
          end
          default: begin
            phase_next = yaz0_pkg::PH_CODE;
          end
        endcase
      end
    end else if (cmd.emit) begin
      out_count_next = oc_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_size    <= '0;
      header_left <= HDR_RST;
      code_bits   <= '0;
      bits_left   <= '0;
      phase       <= yaz0_pkg::PH_CODE;
      ref_first   <= '0;
      ref_second  <= '0;
      out_count   <= '0;
    end else begin
      if (cfg_wr) begin
        out_size <= cfg_data;
      end
      header_left <= header_left_next;
      code_bits   <= code_bits_next;
      bits_left   <= bits_left_next;
      phase       <= phase_next;
      ref_first   <= ref_first_next;
      ref_second  <= ref_second_next;
      out_count   <= out_count_next;
    end
  end

  // copy byte handling
  assign oc_inc     = out_count + SW'(1);
  assign copy_end   = (copy_len == NW'(1)) || (oc_inc >= out_size);
  assign lanes_inc  = acc_lanes + LW'(1);
  assign flush_need = (lanes_inc == LANE_MAX) || copy_end;
  assign out_free   = !out_valid || m_tready;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      acc_new[8*i +: 8] = (acc_lanes == LW'(i)) ? ram_q : acc_bytes[8*i +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (fire && copy_start) begin
      copy_len <= start_len;
      src_ptr  <= src_start;
    end else if (cmd.emit) begin
      copy_len <= copy_len - NW'(1);
      src_ptr  <= src_ptr + AW'(1);
    end
  end

  // unused upper lanes must read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_bytes <= '0;
    end else if (cmd.emit) begin
      acc_bytes <= flush_need ? '0 : acc_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_lanes <= '0;
    end else if (cmd.emit) begin
      acc_lanes <= flush_need ? '0 : lanes_inc;
    end
  end

  // history window
  assign ram_wr_en   = (fire && lit) || cmd.emit;
  assign ram_wr_addr = cmd.emit ? out_count[AW-1:0] : e_oc[AW-1:0];
  assign ram_wr_data = cmd.emit ? ram_q : s_tdata;

  yaz0_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_BYTES)
  ) u_hist (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (cmd.rd),
    .rd_addr (src_ptr),
    .rd_data (ram_q)
  );

  // output register
  assign lit_load  = fire && lit;
  assign copy_load = cmd.emit && flush_need;
  assign out_load  = lit_load || copy_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (lit_load) begin
      out_bytes <= {56'h0, s_tdata};
      out_lanes <= LW'(1);
      out_last  <= 1'b1;
      out_done  <= (e_oc_inc >= out_size);
    end else if (copy_load) begin
      out_bytes <= acc_new;
      out_lanes <= lanes_inc;
      out_last  <= copy_end;
      out_done  <= (oc_inc >= out_size);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'h0, out_lanes, out_bytes};
  assign m_tlast  = out_last;
  assign m_tuser  = out_done;

  always_comb begin
    status.out_free   = out_free;
    status.copy_start = copy_start;
    status.copy_end   = copy_end;
    status.emit_ok    = out_free || !flush_need;
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free)
    else $error("output register loaded while holding an untaken item");

  a_lane_bound: assert property (@(posedge clk) disable iff (rst)
    acc_lanes < LANE_MAX)
    else $error("packing register holds a full set of lanes");

  a_len_live: assert property (@(posedge clk) disable iff (rst)
    cmd.rd |-> (copy_len != '0))
    else $error("history read issued with no copy bytes left");

  a_acc_empty: assert property (@(posedge clk) disable iff (rst)
    (copy_load && copy_end) |=> (acc_lanes == '0))
    else $error("packing register not empty after a copy ended");

endmodule

`default_nettype wire

FILE: rtl/yaz0_stream_decompressor.sv
`default_nettype none

// a literal byte shows up on the output in the cycle after it is accepted
// throughput: header, code, reference and literal bytes are taken one per cycle
//   while the output is free; a back-reference then holds input while each of its
//   bytes is read from history, then written and packed; results carry up to LANES bytes
// reset: synchronous, active high; clears parser, counters, out_size and the output
//   valid; the history memory is not cleared and needs no clearing pass
module yaz0_stream_decompressor #(
  parameter int WINDOW_BYTES = yaz0_pkg::WINDOW_DEF,  // history window depth
  parameter int HEADER_BYTES = yaz0_pkg::HEADER_DEF,  // header bytes skipped per stream
  parameter int LANES        = yaz0_pkg::LANES_DEF    // bytes packed per result, 1..8
) (
  input  wire logic                                clk,
  input  wire logic                                rst,

  // compressed input, one byte per item
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [7:0]                          s_tdata,   // [7:0] data_byte
  input  wire logic                                s_tuser,   // [0] first_of_stream

  // decompressed output
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [yaz0_pkg::TDATA_OUT_W-1:0]         m_tdata,   // [63:0] out_bytes,
                                                              // [67:64] byte_count
  output logic                                     m_tlast,   // last_of_run
  output logic                                     m_tuser,   // [0] stream_done

  // out_size register write
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [yaz0_pkg::SIZE_W-1:0]         cfg_data
);

  yaz0_pkg::cmd_t    cmd;
  yaz0_pkg::status_t status;

  // the size register takes a write in any cycle
  assign cfg_ready = 1'b1;

  // only the accept state lets items in, and only with room at the output
  assign s_tready = cmd.accept;

  yaz0_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .status   (status),
    .cmd      (cmd)
  );

  // parser, copy engine, history window, packing and output register
  yaz0_dp #(
    .WINDOW_BYTES (WINDOW_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .LANES        (LANES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tvalid (s_tvalid),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .cfg_wr   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data)
  );

endmodule

`default_nettype wire

FILE: dv/yaz0_out_check.sv
`default_nettype none

// watches the three channels of the decompressor, predicts every output word
// and compares it with what comes out
module yaz0_out_check (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  input  wire logic                             s_tready,
  input  wire logic [7:0]                       s_tdata,   // [7:0] data_byte
  input  wire logic                             s_tuser,   // [0] first_of_stream
  input  wire logic                             m_tvalid,
  input  wire logic                             m_tready,
  input  wire logic [yaz0_pkg::TDATA_OUT_W-1:0] m_tdata,   // [63:0] out_bytes,
                                                           // [67:64] byte_count
  input  wire logic                             m_tlast,   // last_of_run
  input  wire logic                             m_tuser,   // [0] stream_done
  input  wire logic                             cfg_valid,
  input  wire logic                             cfg_ready,
  input  wire logic [yaz0_pkg::SIZE_W-1:0]      cfg_data,
  output int                                    pending,
  output int                                    fail_count
);

  import yaz0_pkg::*;

  typedef struct packed {
    logic [OUT_W-1:0]  bytes;
    logic [LANE_W-1:0] lanes;
    logic              last;
    logic              done;
  } out_word_t;

  out_word_t         due_words[$];
  logic [7:0]        hist [WINDOW_DEF];
  int                hdr_left;
  int                bits_left;
  logic [7:0]        code_bits;
  logic [7:0]        ref_hi;
  logic [7:0]        ref_lo;
  phase_t            phase;
  logic [SIZE_W-1:0] out_count;
  logic [SIZE_W-1:0] out_size;
  logic [OUT_W-1:0]  acc;
  int                acc_lanes;

  function automatic void flush_lanes();
    out_word_t w;
    if (acc_lanes == 0) return;
    w.bytes = acc;
    w.lanes = acc_lanes[LANE_W-1:0];
    w.last  = 1'b0;
    w.done  = (out_count >= out_size);
    due_words.push_back(w);
    acc = '0;
    acc_lanes = 0;
  endfunction

  function automatic void push_out(logic [7:0] b);
    if (out_count >= out_size) return;
    hist[out_count[DIST_W-1:0]] = b;
    acc = acc | (64'(b) << (8 * acc_lanes));
    acc_lanes++;
    out_count = out_count + SIZE_W'(1);
    if (acc_lanes >= LANES_DEF || out_count >= out_size) flush_lanes();
  endfunction

  function automatic void copy_back(int len);
    logic [DIST_W-1:0] ref_dist;
    logic [DIST_W-1:0] src;
    ref_dist = {ref_hi[3:0], ref_lo};
    for (int i = 0; i < len && out_count < out_size; i++) begin
      src = out_count[DIST_W-1:0] - ref_dist - DIST_W'(1);
      push_out(hist[src]);
    end
  endfunction

  function automatic void choose_phase();
    if (bits_left == 0) phase = PH_CODE;
    else phase = code_bits[7] ? PH_LIT : PH_REF1;
  endfunction

  function automatic void next_code_bit();
    code_bits = code_bits << 1;
    if (bits_left > 0) bits_left--;
    choose_phase();
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic first);
    int        n0;
    out_word_t w;
    n0 = due_words.size();
    acc = '0;
    acc_lanes = 0;
    if (first) begin
      hdr_left  = HEADER_DEF;
      code_bits = '0;
      bits_left = 0;
      phase     = PH_CODE;
      ref_hi    = '0;
      ref_lo    = '0;
      out_count = '0;
    end
    if (hdr_left > 0) begin
      hdr_left--;
      return;
    end
    if (out_count >= out_size) return;
    case (phase)
      PH_CODE: begin
        code_bits = b;
        bits_left = int'(CODE_BITS);
        choose_phase();
      end
      PH_LIT: begin
        push_out(b);
        next_code_bit();
      end
      PH_REF1: begin
        ref_hi = b;
        phase = PH_REF2;
      end
      PH_REF2: begin
        ref_lo = b;
        if (ref_hi[7:4] == 4'd0) begin
          phase = PH_EXT;
        end else begin
          copy_back(int'(ref_hi[7:4]) + int'(SHORT_BIAS));
          next_code_bit();
        end
      end
      PH_EXT: begin
        copy_back(int'(b) + int'(EXT_BIAS));
        next_code_bit();
      end
      default: phase = PH_CODE;
    endcase
    flush_lanes();
    // the final word of this input byte carries the run marker
    if (due_words.size() > n0) begin
      w = due_words.pop_back();
      w.last = 1'b1;
      due_words.push_back(w);
    end
  endfunction

  always @(posedge clk) begin
    out_word_t w;
    if (rst) begin
      due_words.delete();
      hdr_left  = HEADER_DEF;
      code_bits = '0;
      bits_left = 0;
      phase     = PH_CODE;
      ref_hi    = '0;
      ref_lo    = '0;
      out_count = '0;
      out_size  = '0;
    end else begin
      if (cfg_valid && cfg_ready) out_size = cfg_data;
      if (s_tvalid && s_tready) decode_byte(s_tdata, s_tuser);
      if (m_tvalid && m_tready) begin
        if (due_words.size() == 0) begin
          $error("unexpected item: out_bytes %h byte_count %0d", m_tdata[OUT_W-1:0],
                 m_tdata[OUT_W +: LANE_W]);
          fail_count++;
        end else begin
          w = due_words.pop_front();
          if (m_tdata[OUT_W-1:0] !== w.bytes) begin
            $error("out_bytes: expected %h, got %h", w.bytes, m_tdata[OUT_W-1:0]);
            fail_count++;
          end
          if (m_tdata[OUT_W +: LANE_W] !== w.lanes) begin
            $error("byte_count: expected %0d, got %0d", w.lanes, m_tdata[OUT_W +: LANE_W]);
            fail_count++;
          end
          if (m_tlast !== w.last) begin
            $error("last_of_run: expected %b, got %b", w.last, m_tlast);
            fail_count++;
          end
          if (m_tuser !== w.done) begin
            $error("stream_done: expected %b, got %b", w.done, m_tuser);
            fail_count++;
          end
        end
      end
    end
    pending <= due_words.size();
  end

endmodule

`default_nettype wire

FILE: dv/yaz0_stream_decompressor_test.sv
`default_nettype none

module yaz0_stream_decompressor_test;

  import yaz0_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [7:0]             s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_tdata;
  logic                   m_tlast;
  logic                   m_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [SIZE_W-1:0]      cfg_data = '0;

  int pending;
  int fail_count;
  int send_gap_pct;    // chance per cycle that the sender holds back
  int hold_pct;        // chance per cycle that the receiver stalls
  int items_done;
  int stream_left;     // items still allowed in the current stream
  bit mid_write;

  // stimulus-side view of the output count and of which history slots hold data
  int gen_count;
  int gen_size;
  bit filled [WINDOW_DEF];
  int filled_n;

  yaz0_stream_decompressor dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  yaz0_out_check u_check (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .pending   (pending),
    .fail_count(fail_count)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= hold_pct);
  end

  task automatic put_byte(input logic [7:0] b, input logic first);
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= first;
    do @(posedge clk); while (!s_tready);
  endtask

  // one counted item of the current stream
  task automatic feed(input logic [7:0] b, input logic first);
    put_byte(b, first);
    stream_left--;
    items_done++;
  endtask

  // drain: no input, every predicted word delivered, then a few spare cycles
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_size(input int v);
    cfg_valid <= 1'b1;
    cfg_data  <= v[SIZE_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // a copy must only read history slots that were written at some point
  function automatic bit dist_ok(int len, int d);
    for (int i = 0; i < len && i <= d && gen_count + i < gen_size; i++)
      if (!filled[(gen_count + i - d - 1) & (WINDOW_DEF - 1)]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic int pick_dist(int len);
    int d;
    for (int t = 0; t < 6; t++) begin
      d = (t % 2 == 0) ? $urandom_range(WINDOW_DEF - 1) : $urandom_range(15);
      if (dist_ok(len, d)) return d;
    end
    // fall back to data already produced in this stream
    return $urandom_range(0, (gen_count < WINDOW_DEF ? gen_count : WINDOW_DEF) - 1);
  endfunction

  function automatic void note_output(int len);
    for (int i = 0; i < len && gen_count < gen_size; i++) begin
      if (!filled[gen_count & (WINDOW_DEF - 1)]) begin
        filled[gen_count & (WINDOW_DEF - 1)] = 1'b1;
        filled_n++;
      end
      gen_count++;
    end
  endfunction

  function automatic int choose_size();
    case ($urandom_range(7))
      0:       return 0;
      1:       return 1;
      2, 3:    return $urandom_range(2, 64);
      4, 5:    return $urandom_range(65, 800);
      6:       return $urandom_range(801, 67108863);
      default: return 67108864;
    endcase
  endfunction

  // one stream: header, then code groups with literals and back-references;
  // the stream may be cut anywhere, the next first flag restarts the parser
  task automatic run_stream();
    int         n;
    int         ext;
    int         len;
    int         d;
    logic [7:0] code;
    gen_count = 0;
    for (int k = 0; k < HEADER_DEF; k++) begin
      if (stream_left == 0) return;
      feed(8'($urandom_range(255)), k == 0);
    end
    while (stream_left > 0 && gen_count < gen_size) begin
      if (mid_write && $urandom_range(3) == 0) begin
        // size change while the stream is open, possibly below what is out
        mid_write = 1'b0;
        settle();
        gen_size = $urandom_range(0, gen_count + 40);
        write_size(gen_size);
        continue;
      end
      code = 8'($urandom_range(255));
      if (gen_count == 0 && filled_n < WINDOW_DEF) code[7] = 1'b1;
      feed(code, 1'b0);
      for (int bitn = 7; bitn >= 0 && stream_left > 0 && gen_count < gen_size; bitn--) begin
        if (code[bitn]) begin
          feed(8'($urandom_range(255)), 1'b0);
          note_output(1);
        end else begin
          n   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 15);
          ext = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(24);
          len = (n == 0) ? ext + int'(EXT_BIAS) : n + int'(SHORT_BIAS);
          d   = pick_dist(len);
          feed({n[3:0], d[11:8]}, 1'b0);
          if (stream_left == 0) break;
          feed(d[7:0], 1'b0);
          if (n == 0) begin
            if (stream_left == 0) break;
            feed(ext[7:0], 1'b0);
          end
          note_output(len);
        end
      end
    end
    // a stream that has finished ignores whatever follows
    if (gen_count >= gen_size) begin
      repeat ($urandom_range(2)) put_byte(8'($urandom_range(255)), 1'b0);
    end
  endtask

  task automatic random_phase(input int gap, input int stall, input int quota);
    settle();
    send_gap_pct = gap;
    hold_pct <= stall;
    items_done = 0;
    while (items_done < quota) begin
      settle();
      if ($urandom_range(4) != 0) begin
        gen_size = choose_size();
        write_size(gen_size);
      end
      stream_left = ($urandom_range(7) == 0) ? $urandom_range(1, 15) : $urandom_range(20, 90);
      // keep the phase close to its share of items
      if (stream_left > quota - items_done) stream_left = quota - items_done;
      mid_write = ($urandom_range(7) == 0);
      run_stream();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed stream: literal extremes, overlapping short copy, long copy
    // with extension byte cut off at the configured size, then an ignored byte
    send_gap_pct = 12;
    hold_pct <= 70;
    write_size(24);
    put_byte(8'hFF, 1'b1);
    repeat (HEADER_DEF - 2) put_byte(8'($urandom_range(255)), 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'hC0, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(8'hF0, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'h01, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(8'h5A, 1'b0);
    gen_size = 24;

    random_phase(12, 70, 115);
    random_phase(70, 12, 115);
    random_phase(0, 0, 115);
    settle();

    if (fail_count == 0) begin
      $display("PASS yaz0_stream_decompressor");
    end else begin
      $display("FAIL yaz0_stream_decompressor");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL yaz0_stream_decompressor");
    $finish;
  end

endmodule

`default_nettype wire
